/* sv/pppfc_pkg.sv */
// Package with the shared codes, constants and result type of the PPP frame collector.
package pppfc_pkg;

	localparam logic [7:0] ESC_BYTE  = 8'h7D;
	localparam logic [7:0] ESC_XOR   = 8'h20;
	localparam logic [7:0] FLAG_BYTE = 8'h7E;

	localparam logic [15:0] FRAME_LEN_MAX = 16'hFFFF;

	typedef enum logic [1:0] {
		REQ_ADD       = 2'd0,
		REQ_CLR_FRAME = 2'd1,
		REQ_CLR_COUNT = 2'd2,
		REQ_READ      = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_EMPTY = 2'd0,
		ST_BUSY  = 2'd1,
		ST_DONE  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_OVERFLOW = 2'd1,
		ERR_REJECT   = 2'd2
	} err_t;

	typedef struct packed {
		err_t        err;
		status_t     status;
		logic [11:0] buffer_length;
		logic [15:0] frame_length;
	} result_t;

endpackage

/* sv/pppfc_if.sv */
// Handshake interfaces for the request and result channels of the frame collector.
interface pppfc_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [7:0]  data_byte;
	logic [10:0] read_index;

	modport source(output valid, output req_type, output data_byte, output read_index,
		input ready);
	modport sink(input valid, input req_type, input data_byte, input read_index,
		output ready);
endinterface

interface pppfc_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  error_code;
	logic [1:0]  frame_status;
	logic [11:0] buffer_length;
	logic [15:0] frame_length;
	logic [7:0]  read_data;

	modport source(output valid, output error_code, output frame_status,
		output buffer_length, output frame_length, output read_data, input ready);
	modport sink(input valid, input error_code, input frame_status,
		input buffer_length, input frame_length, input read_data, output ready);
endinterface

/* sv/pppfc_store.sv */
// Frame byte store: one write port and one registered read port.
module pppfc_store #(
	parameter int DEPTH = 2048,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// The read register only moves on a read, so it holds while the result stalls.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* sv/pppfc_ctrl.sv */
// Frame collection state, byte unstuffing and the next result of each request.
module pppfc_ctrl #(
	parameter int MAX_FRAME = 2048,
	parameter int AW        = $clog2(MAX_FRAME),
	parameter int CW        = $clog2(MAX_FRAME + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [1:0]        req_type,
	input  logic [7:0]        data_byte,
	input  logic              remove_framing,
	output logic              wr_en,
	output logic [AW-1:0]     wr_addr,
	output logic [7:0]        wr_data,
	output pppfc_pkg::result_t result
);

	pppfc_pkg::status_t status_q, status_n;
	logic [CW-1:0]      count_q, count_n;
	logic [15:0]        fcount_q, fcount_n;
	logic               esc_q, esc_n;
	pppfc_pkg::err_t    err;
	logic [7:0]         byte_u;
	logic               put;
	logic [CW-1:0]      put_base;
	logic [15:0]        fput_base;
	logic               skip;

	always_comb begin
		status_n  = status_q;
		count_n   = count_q;
		fcount_n  = fcount_q;
		esc_n     = esc_q;
		err       = pppfc_pkg::ERR_NONE;
		byte_u    = data_byte;
		put       = 1'b0;
		skip      = 1'b0;
		put_base  = count_q;
		fput_base = fcount_q;

		case (pppfc_pkg::req_t'(req_type))
			pppfc_pkg::REQ_ADD: begin
				if (status_q == pppfc_pkg::ST_DONE) begin
					err = pppfc_pkg::ERR_REJECT;
				end else begin
					if (remove_framing) begin
						if (data_byte == pppfc_pkg::ESC_BYTE && !esc_q) begin
							esc_n = 1'b1;
							skip  = 1'b1;
						end else if (esc_q) begin
							esc_n  = 1'b0;
							byte_u = data_byte ^ pppfc_pkg::ESC_XOR;
						end
					end
					if (!skip) begin
						if (status_q == pppfc_pkg::ST_EMPTY) begin
							// A new frame always starts from an empty buffer.
							put_base  = '0;
							fput_base = '0;
							put       = 1'b1;
							status_n  = pppfc_pkg::ST_BUSY;
						end else if (byte_u != pppfc_pkg::FLAG_BYTE) begin
							if (count_q < CW'(MAX_FRAME - 1)) begin
								put = 1'b1;
							end else begin
								esc_n = esc_q;
								err   = pppfc_pkg::ERR_OVERFLOW;
							end
						end else begin
							put      = 1'b1;
							status_n = pppfc_pkg::ST_DONE;
						end
					end
				end
			end
			pppfc_pkg::REQ_CLR_FRAME: begin
				count_n  = '0;
				fcount_n = '0;
				status_n = pppfc_pkg::ST_EMPTY;
			end
			pppfc_pkg::REQ_CLR_COUNT: begin
				count_n = '0;
			end
			default: begin
			end
		endcase

		wr_en   = 1'b0;
		wr_addr = put_base[AW-1:0];
		wr_data = byte_u;
		if (put) begin
			count_n  = put_base;
			fcount_n = fput_base;
			if (put_base < CW'(MAX_FRAME)) begin
				wr_en   = accept;
				count_n = put_base + CW'(1);
			end
			if (fput_base != pppfc_pkg::FRAME_LEN_MAX) begin
				fcount_n = fput_base + 16'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= pppfc_pkg::ST_EMPTY;
			count_q  <= '0;
			fcount_q <= '0;
			esc_q    <= 1'b0;
		end else if (accept) begin
			status_q <= status_n;
			count_q  <= count_n;
			fcount_q <= fcount_n;
			esc_q    <= esc_n;
		end
	end

	assign result.err           = err;
	assign result.status        = status_n;
	assign result.buffer_length = 12'(count_n);
	assign result.frame_length  = fcount_n;

endmodule

/* sv/ppp_hdlc_frame_collector_unit.sv */
// Top level of the PPP frame collector with HDLC byte unstuffing.
// The unit takes one request per clock cycle while the result channel is not stalled, and
// returns its result in the cycle after the transfer, from a single output register; a new
// request is taken whenever that register is empty or is being emptied in the same cycle.
// The throughput is set by the frame state update and by the frame store, which has one write
// and one registered read port. The store is not cleared after reset: an entry that was never
// written reads as whatever it holds.
module ppp_hdlc_frame_collector_unit #(
	parameter int MAX_FRAME = 2048
) (
	input  logic            clk,
	input  logic            arst_n,
	pppfc_req_if.sink       req_ch,
	pppfc_rsp_if.source     rsp_ch,
	input  logic            cfg_we,
	input  logic            cfg_wdata
);

	localparam int AW = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;
	localparam int CW = $clog2(MAX_FRAME + 1);

	logic               accept;
	logic               remove_framing_q;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic [7:0]         wr_data;
	logic               rd_en;
	logic [7:0]         rd_data;
	pppfc_pkg::result_t result;
	pppfc_pkg::result_t result_s1;
	logic               read_hit_s1;
	logic               valid_s1;

	assign req_ch.ready = !valid_s1 || rsp_ch.ready;
	assign accept       = req_ch.valid && req_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remove_framing_q <= 1'b1;
		end else if (cfg_we) begin
			remove_framing_q <= cfg_wdata;
		end
	end

	pppfc_ctrl #(
		.MAX_FRAME(MAX_FRAME),
		.AW       (AW),
		.CW       (CW)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.req_type      (req_ch.req_type),
		.data_byte     (req_ch.data_byte),
		.remove_framing(remove_framing_q),
		.wr_en         (wr_en),
		.wr_addr       (wr_addr),
		.wr_data       (wr_data),
		.result        (result)
	);

	// Reads beyond the store answer zero.
	assign rd_en = accept && (pppfc_pkg::req_t'(req_ch.req_type) == pppfc_pkg::REQ_READ)
		&& (32'(req_ch.read_index) < 32'(MAX_FRAME));

	pppfc_store #(
		.DEPTH(MAX_FRAME),
		.AW   (AW)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(AW'(req_ch.read_index)),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (rsp_ch.ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_s1   <= result;
			read_hit_s1 <= rd_en;
		end
	end

	assign rsp_ch.valid         = valid_s1;
	assign rsp_ch.error_code    = result_s1.err;
	assign rsp_ch.frame_status  = result_s1.status;
	assign rsp_ch.buffer_length = result_s1.buffer_length;
	assign rsp_ch.frame_length  = result_s1.frame_length;
	assign rsp_ch.read_data     = read_hit_s1 ? rd_data : 8'd0;

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> rsp_ch.valid)
		else $error("request transfer did not produce a result");

	a_reject_when_done: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_ch.valid && rsp_ch.error_code == pppfc_pkg::ERR_REJECT)
		|-> (rsp_ch.frame_status == pppfc_pkg::ST_DONE))
		else $error("byte rejected while frame not complete");

	a_overflow_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_ch.valid && rsp_ch.error_code == pppfc_pkg::ERR_OVERFLOW)
		|-> (rsp_ch.frame_status == pppfc_pkg::ST_BUSY))
		else $error("overflow reported outside a frame in progress");

	a_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_ch.valid && rsp_ch.error_code != pppfc_pkg::ERR_NONE)
		|-> (rsp_ch.read_data == 8'd0))
		else $error("read data on an add request");

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for the PPP frame collector: drives requests, checks results.
`timescale 1ns / 100ps

typedef struct packed {
	pppfc_pkg::result_t res;
	logic [7:0]         read_data;
} outcome_t;

// Tracks the collector state transfer by transfer and holds the results still to come.
class frame_scoreboard;
	int unsigned        cap;
	logic [7:0]         frame_img[];
	int unsigned        written_top;
	int unsigned        store_count;
	int unsigned        frame_count;
	pppfc_pkg::status_t status;
	bit                 esc_mark;
	bit                 unframing;
	outcome_t           due_results[$];
	int unsigned        checked;
	int unsigned        mismatches;
	int unsigned        closed_frames;
	int unsigned        overflows;
	int unsigned        rejects;

	function new(int unsigned depth);
		cap = depth;
		frame_img = new[depth];
		written_top = 0;
		store_count = 0;
		frame_count = 0;
		status = pppfc_pkg::ST_EMPTY;
		esc_mark = 1'b0;
		unframing = 1'b1;
		checked = 0;
		mismatches = 0;
		closed_frames = 0;
		overflows = 0;
		rejects = 0;
	endfunction

	function void store_byte(logic [7:0] value);
		if (store_count < cap) begin
			frame_img[store_count] = value;
			store_count++;
			if (store_count > written_top)
				written_top = store_count;
		end
		if (frame_count < pppfc_pkg::FRAME_LEN_MAX)
			frame_count++;
	endfunction

	function pppfc_pkg::err_t collect_byte(logic [7:0] line_byte);
		bit         mark_in;
		logic [7:0] value;
		mark_in = esc_mark;
		value = line_byte;
		if (status == pppfc_pkg::ST_DONE)
			return pppfc_pkg::ERR_REJECT;
		if (unframing) begin
			if (value == pppfc_pkg::ESC_BYTE && !esc_mark) begin
				esc_mark = 1'b1;
				return pppfc_pkg::ERR_NONE;
			end
			if (esc_mark) begin
				esc_mark = 1'b0;
				value = value ^ pppfc_pkg::ESC_XOR;
			end
		end
		if (status == pppfc_pkg::ST_EMPTY) begin
			store_count = 0;
			frame_count = 0;
			store_byte(value);
			status = pppfc_pkg::ST_BUSY;
			return pppfc_pkg::ERR_NONE;
		end
		// The flag test comes after unescaping, so an escaped flag closes the frame too.
		if (value != pppfc_pkg::FLAG_BYTE) begin
			if (store_count < cap - 1) begin
				store_byte(value);
				return pppfc_pkg::ERR_NONE;
			end
			esc_mark = mark_in;
			return pppfc_pkg::ERR_OVERFLOW;
		end
		store_byte(value);
		status = pppfc_pkg::ST_DONE;
		closed_frames++;
		return pppfc_pkg::ERR_NONE;
	endfunction

	function void note_request(pppfc_pkg::req_t kind, logic [7:0] data, logic [10:0] index);
		outcome_t due;
		due = '0;
		case (kind)
			pppfc_pkg::REQ_ADD: begin
				due.res.err = collect_byte(data);
				if (due.res.err == pppfc_pkg::ERR_OVERFLOW)
					overflows++;
				if (due.res.err == pppfc_pkg::ERR_REJECT)
					rejects++;
			end
			pppfc_pkg::REQ_CLR_FRAME: begin
				store_count = 0;
				frame_count = 0;
				status = pppfc_pkg::ST_EMPTY;
			end
			pppfc_pkg::REQ_CLR_COUNT: begin
				store_count = 0;
			end
			default: begin
				if (index < cap)
					due.read_data = frame_img[index];
			end
		endcase
		due.res.status = status;
		due.res.buffer_length = 12'(store_count);
		due.res.frame_length = 16'(frame_count);
		due_results.push_back(due);
	endfunction

	function void check_result(outcome_t got);
		outcome_t want;
		if (due_results.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display({"ERROR: result with nothing expected: ",
					"err %0d status %0d len %0d/%0d data %h"},
					got.res.err, got.res.status, got.res.buffer_length,
					got.res.frame_length, got.read_data);
			return;
		end
		want = due_results.pop_front();
		checked++;
		if (got.res.err !== want.res.err || got.res.status !== want.res.status ||
				got.res.buffer_length !== want.res.buffer_length ||
				got.res.frame_length !== want.res.frame_length ||
				got.read_data !== want.read_data) begin
			mismatches++;
			if (mismatches <= 10)
				$display({"ERROR: result %0d (expected/actual): err %0d/%0d status %0d/%0d ",
					"buffer_length %0d/%0d frame_length %0d/%0d read_data %h/%h"},
					checked, want.res.err, got.res.err, want.res.status, got.res.status,
					want.res.buffer_length, got.res.buffer_length,
					want.res.frame_length, got.res.frame_length,
					want.read_data, got.read_data);
		end
	endfunction

	function int unsigned pending();
		return due_results.size();
	endfunction
endclass

module testbench;
	localparam int FRAME_CAP     = 2048;
	localparam int ITEM_TARGET   = 2400;
	localparam int SETTLE_CYCLES = 4;
	localparam int RUN_LIMIT_NS  = 10_000_000;

	typedef enum int {
		STALL_NONE,
		STALL_COIN,
		STALL_EVERY4,
		STALL_RARE
	} stall_mode_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	pppfc_req_if req_ch();
	pppfc_rsp_if rsp_ch();

	ppp_hdlc_frame_collector_unit #(.MAX_FRAME(FRAME_CAP)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_ch   (req_ch),
		.rsp_ch   (rsp_ch),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	frame_scoreboard sb = new(FRAME_CAP);
	int unsigned items_sent = 0;
	int unsigned burst_left = 0;
	int unsigned cfg_writes = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Presents one request and returns after its transfer; valid stays high for the next one.
	task automatic push_request(input pppfc_pkg::req_t kind, input logic [7:0] data,
			input logic [10:0] index);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req_ch.valid      <= 1'b1;
		req_ch.req_type   <= kind;
		req_ch.data_byte  <= data;
		req_ch.read_index <= index;
		@(posedge clk);
		while (req_ch.ready !== 1'b1)
			@(posedge clk);
		sb.note_request(kind, data, index);
		items_sent++;
	endtask

	task automatic send_add(input logic [7:0] value);
		push_request(pppfc_pkg::REQ_ADD, value, 11'($urandom));
	endtask

	task automatic send_read(input logic [10:0] index);
		push_request(pppfc_pkg::REQ_READ, 8'($urandom), index);
	endtask

	task automatic send_clear(input pppfc_pkg::req_t kind);
		push_request(kind, 8'($urandom), 11'($urandom));
	endtask

	task automatic wait_results_drained();
		req_ch.valid <= 1'b0;
		burst_left = 0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_unframing(input bit value);
		wait_results_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.unframing = value;
		cfg_writes++;
	endtask

	// Entries are always written from index zero upward, so the written ones form a prefix.
	function automatic logic [10:0] any_written_index();
		case ($urandom_range(0, 7))
			0: return 11'd0;
			1: return 11'(sb.written_top - 1);
			default: return 11'($urandom_range(0, sb.written_top - 1));
		endcase
	endfunction

	function automatic logic [7:0] body_byte();
		logic [7:0] value;
		do
			value = 8'($urandom);
		while (value == pppfc_pkg::FLAG_BYTE || value == pppfc_pkg::ESC_BYTE);
		return value;
	endfunction

	// A byte that follows an escape without turning into a flag in either mode.
	function automatic logic [7:0] escapable_byte();
		logic [7:0] value;
		do
			value = 8'($urandom);
		while (value == (pppfc_pkg::FLAG_BYTE ^ pppfc_pkg::ESC_XOR) ||
			value == pppfc_pkg::FLAG_BYTE);
		return value;
	endfunction

	task automatic send_frame(input int unsigned body_len);
		int unsigned n;
		if (sb.status == pppfc_pkg::ST_DONE) begin
			if ($urandom_range(0, 4) == 0)
				send_add(8'($urandom));
			send_clear(pppfc_pkg::REQ_CLR_FRAME);
		end else if (sb.status == pppfc_pkg::ST_BUSY && $urandom_range(0, 1) == 0) begin
			send_clear(pppfc_pkg::REQ_CLR_FRAME);
		end
		// The opening byte may be anything, a flag or an escape included.
		send_add(8'($urandom));
		for (n = 0; n < body_len; n++) begin
			case ($urandom_range(0, 39))
				0, 1, 2, 3: begin
					send_add(pppfc_pkg::ESC_BYTE);
					send_add(escapable_byte());
				end
				4, 5: send_read(any_written_index());
				6: send_clear(pppfc_pkg::REQ_CLR_COUNT);
				default: send_add(body_byte());
			endcase
		end
		case ($urandom_range(0, 9))
			0: begin
				send_add(pppfc_pkg::ESC_BYTE);
				send_add(pppfc_pkg::FLAG_BYTE ^ pppfc_pkg::ESC_XOR);
			end
			1: begin
				// The frame stays open.
			end
			default: send_add(pppfc_pkg::FLAG_BYTE);
		endcase
	endtask

	// The receiver switches between stall patterns, each held for a random stretch.
	initial begin
		stall_mode_t mode;
		int unsigned mode_left;
		int unsigned tick;
		rsp_ch.ready <= 1'b0;
		mode = STALL_NONE;
		mode_left = 0;
		tick = 0;
		forever begin
			@(posedge clk);
			if (mode_left == 0) begin
				mode = stall_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(16, 160);
			end
			mode_left--;
			tick++;
			case (mode)
				STALL_NONE: rsp_ch.ready <= 1'b1;
				STALL_COIN: rsp_ch.ready <= 1'($urandom_range(0, 1));
				STALL_EVERY4: rsp_ch.ready <= (tick % 4) != 3;
				default: rsp_ch.ready <= ($urandom_range(0, 5) != 0);
			endcase
		end
	end

	initial begin
		outcome_t got;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
				got.res.err           = pppfc_pkg::err_t'(rsp_ch.error_code);
				got.res.status        = pppfc_pkg::status_t'(rsp_ch.frame_status);
				got.res.buffer_length = rsp_ch.buffer_length;
				got.res.frame_length  = rsp_ch.frame_length;
				got.read_data         = rsp_ch.read_data;
				sb.check_result(got);
			end
		end
	end

	initial begin
		int unsigned     n;
		pppfc_pkg::req_t kind;

		arst_n            <= 1'b0;
		cfg_we            <= 1'b0;
		cfg_wdata         <= 1'b1;
		req_ch.valid      <= 1'b0;
		req_ch.req_type   <= pppfc_pkg::REQ_ADD;
		req_ch.data_byte  <= 8'h00;
		req_ch.read_index <= 11'd0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Escapes around the start of a frame, clears, rejects and raw mode with a pending mark.
		send_add(pppfc_pkg::ESC_BYTE);
		send_clear(pppfc_pkg::REQ_CLR_FRAME);
		send_add(pppfc_pkg::FLAG_BYTE ^ pppfc_pkg::ESC_XOR);
		send_add(8'h00);
		send_add(8'hFF);
		send_add(pppfc_pkg::ESC_BYTE);
		send_add(pppfc_pkg::ESC_BYTE);
		send_clear(pppfc_pkg::REQ_CLR_COUNT);
		send_add(8'h41);
		send_read(11'd0);
		send_add(pppfc_pkg::ESC_BYTE);
		write_unframing(1'b0);
		send_add(pppfc_pkg::ESC_BYTE);
		send_add(pppfc_pkg::FLAG_BYTE);
		send_add(8'h33);
		send_read(11'd1);
		send_read(11'd3);
		send_clear(pppfc_pkg::REQ_CLR_FRAME);
		write_unframing(1'b1);
		send_add(8'h10);
		send_add(pppfc_pkg::ESC_BYTE);
		send_add(pppfc_pkg::FLAG_BYTE ^ pppfc_pkg::ESC_XOR);
		send_add(pppfc_pkg::ESC_BYTE);
		send_read(11'd2);
		send_clear(pppfc_pkg::REQ_CLR_COUNT);
		send_add(8'h55);
		send_clear(pppfc_pkg::REQ_CLR_FRAME);

		// One frame filled to the last free entry, then dropped bytes and a flag that still fits.
		send_add(body_byte());
		while (sb.store_count < FRAME_CAP - 1) begin
			if ($urandom_range(0, 63) == 0) begin
				send_add(pppfc_pkg::ESC_BYTE);
				send_add(escapable_byte());
			end else begin
				send_add(body_byte());
			end
		end
		send_add(body_byte());
		send_add(pppfc_pkg::ESC_BYTE);
		send_add(escapable_byte());
		send_add(pppfc_pkg::ESC_BYTE);
		send_add(pppfc_pkg::FLAG_BYTE ^ pppfc_pkg::ESC_XOR);
		for (n = 0; n < 24; n++)
			send_read(any_written_index());
		send_read(11'(FRAME_CAP - 1));
		send_clear(pppfc_pkg::REQ_CLR_FRAME);

		// Mostly well-formed frames with random content, some noise and mode changes.
		while (items_sent < ITEM_TARGET) begin
			case ($urandom_range(0, 39))
				0: write_unframing(!sb.unframing);
				1, 2, 3, 4: begin
					for (n = $urandom_range(1, 6); n > 0; n--) begin
						kind = pppfc_pkg::req_t'($urandom_range(0, 3));
						push_request(kind, 8'($urandom),
							(kind == pppfc_pkg::REQ_READ) ? any_written_index()
								: 11'($urandom));
					end
				end
				5: send_frame($urandom_range(60, 160));
				default: send_frame($urandom_range(0, 12));
			endcase
		end

		wait_results_drained();
		$display("Run covered %0d requests, %0d mode writes, %0d closed frames,",
			items_sent, cfg_writes, sb.closed_frames);
		$display("%0d overflow drops and %0d rejected bytes; %0d results compared, %0d wrong.",
			sb.overflows, sb.rejects, sb.checked, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#RUN_LIMIT_NS;
		$display("FAILURE");
		$finish;
	end
endmodule
